// ----- rtl/srbm_pkg.sv -----
// ----------------------------------------------------------------------------
// srbm_pkg
// Shared types and constants of the SPI register burst master.
// ----------------------------------------------------------------------------
package srbm_pkg;

	localparam int COUNT_WIDTH_DEF = 8;

	// command byte decoration
	localparam logic [7:0] CMD_READ_FLAG = 8'h80;
	localparam logic [7:0] CMD_AINC_FLAG = 8'h40;
	// dummy byte shifted out during reads
	localparam logic [7:0] READ_FILL     = 8'hFF;

	// item opcodes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_CMD  = 2'd1,
		ST_DATA = 2'd2
	} seq_state_t;

	typedef struct packed {
		logic       cmd;
		logic [5:0] reg_addr;
		logic       is_read;
		logic [7:0] byte_count;
		logic [7:0] wdata;
		logic       miso;
	} item_t;

	typedef struct packed {
		logic       ncs;
		logic       sck;
		logic       mosi;
		logic [7:0] rdata;
		logic       rdata_valid;
		logic       last;
		logic       wdata_taken;
		logic       busy_res;
	} result_t;

endpackage

// ----- rtl/srbm_if.sv -----
// ----------------------------------------------------------------------------
// srbm_if
// Valid/ready channels of the SPI register burst master.
// ----------------------------------------------------------------------------
interface srbm_item_if import srbm_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface srbm_result_if import srbm_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/srbm_in_reg.sv -----
// ----------------------------------------------------------------------------
// srbm_in_reg
// Input register: captures one word and holds it until the sequencer takes it.
// ----------------------------------------------------------------------------
module srbm_in_reg import srbm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	srbm_item_if.sink  item,
	input  logic       adv,
	output item_t      item_s1,
	output logic       valid_s1
);

	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

endmodule

// ----- rtl/srbm_seq.sv -----
// ----------------------------------------------------------------------------
// srbm_seq
// Transaction sequencer: one half bit per step, drives the pin levels and
// shifts the command and data bytes.
// ----------------------------------------------------------------------------
module srbm_seq import srbm_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item_s1,
	output result_t res
);

	seq_state_t             state_q, state_d;
	logic [7:0]             shift_q, shift_d;
	logic [2:0]             bit_idx_q, bit_idx_d;
	logic                   phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] left_q, left_d;
	logic                   rmode_q, rmode_d;

	logic active;
	logic byte_end;
	logic [7:0] sampled;

	assign active   = (state_q == ST_CMD) || (state_q == ST_DATA);
	assign byte_end = active && !phase_q && (bit_idx_q == 3'd0);

	always_comb begin
		sampled = shift_q;
		sampled[bit_idx_q] = item_s1.miso;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CMD, ST_DATA: begin
				if (byte_end) begin
					state_d = (left_q == '0) ? ST_IDLE : ST_DATA;
				end
			end
			default: begin
				state_d = (item_s1.cmd == CMD_START) ? ST_CMD : ST_IDLE;
			end
		endcase
	end

	// datapath and pin levels
	always_comb begin
		shift_d   = shift_q;
		bit_idx_d = bit_idx_q;
		phase_d   = phase_q;
		left_d    = left_q;
		rmode_d   = rmode_q;
		res       = '0;
		res.ncs   = 1'b1;
		res.sck   = 1'b1;
		if (!active) begin
			if (item_s1.cmd == CMD_START) begin
				shift_d      = CMD_AINC_FLAG | {2'b00, item_s1.reg_addr}
				             | (item_s1.is_read ? CMD_READ_FLAG : 8'h00);
				bit_idx_d    = 3'd7;
				phase_d      = 1'b1;
				left_d       = COUNT_WIDTH'(item_s1.byte_count);
				rmode_d      = item_s1.is_read;
				res.ncs      = 1'b0;
				res.busy_res = 1'b1;
			end
		end else begin
			res.ncs      = 1'b0;
			res.busy_res = 1'b1;
			res.mosi     = shift_q[bit_idx_q];
			if (phase_q) begin
				// falling edge: drive only
				phase_d = 1'b0;
				res.sck = 1'b0;
			end else begin
				phase_d = 1'b1;
				shift_d = sampled;
				if (bit_idx_q != 3'd0) begin
					bit_idx_d = bit_idx_q - 3'd1;
				end else begin
					bit_idx_d = 3'd7;
					if ((state_q == ST_DATA) && rmode_q) begin
						res.rdata       = sampled;
						res.rdata_valid = 1'b1;
					end
					if (left_q == '0) begin
						res.last = 1'b1;
					end else begin
						left_d = left_q - COUNT_WIDTH'(1);
						if (rmode_q) begin
							shift_d = READ_FILL;
						end else begin
							shift_d         = item_s1.wdata;
							res.wdata_taken = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			shift_q   <= '0;
			bit_idx_q <= 3'd7;
			phase_q   <= 1'b1;
			left_q    <= '0;
			rmode_q   <= 1'b0;
		end else if (step) begin
			state_q   <= state_d;
			shift_q   <= shift_d;
			bit_idx_q <= bit_idx_d;
			phase_q   <= phase_d;
			left_q    <= left_d;
			rmode_q   <= rmode_d;
		end
	end

endmodule

// ----- rtl/srbm_out_reg.sv -----
// ----------------------------------------------------------------------------
// srbm_out_reg
// Result register: holds one finished word until the receiver takes it.
// ----------------------------------------------------------------------------
module srbm_out_reg import srbm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  result_t      res,
	srbm_result_if.source result,
	output logic         room
);

	logic    valid_q;
	result_t data_q;

	assign room         = !valid_q || result.ready;
	assign result.valid = valid_q;
	assign result.data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

endmodule

// ----- rtl/spi_register_burst_master_core.sv -----
// ----------------------------------------------------------------------------
// spi_register_burst_master_core
// SPI mode 3 register burst master, one half bit per input word.
// ----------------------------------------------------------------------------
// Channels: item (valid/ready) carries start and tick words; result
// (valid/ready) returns exactly one word per item with the pin levels
// ncs, sck, mosi and the status flags of that half bit.
// A start word while idle lowers chip select and loads the command byte
// (address, auto-increment flag, read flag); each following tick moves
// one half bit: clock low drives mosi, clock high samples miso.
// Path: a word is captured in the input register, stepped through the
// sequencer once the result register has room, and lands in the result
// register.
// Throughput: one word per cycle while the receiver does not stall.
// Reset: both registers empty, sequencer idle with the clock high.
// Receiver stall: the result register holds its word, the sequencer
// stops, and the input register fills; item.ready falls once it is full.
// ----------------------------------------------------------------------------
module spi_register_burst_master_core import srbm_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	srbm_item_if.sink     item,
	srbm_result_if.source result
);

	item_t   item_s1;
	logic    valid_s1;
	logic    room;
	logic    adv;
	result_t res;

	assign adv = valid_s1 && room;

	srbm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.adv      (adv),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	srbm_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.item_s1 (item_s1),
		.res     (res)
	);

	srbm_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.res    (res),
		.result (result),
		.room   (room)
	);

	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> result.valid)
		else $error("advanced word did not reach the result register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1)
		else $error("input word lost during stall");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.last |-> result.data.busy_res && !result.data.ncs
		&& result.data.sck)
		else $error("last flagged outside a rising clock of a transaction");

	a_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.rdata_valid |-> !result.data.wdata_taken
		&& result.data.sck)
		else $error("read byte and write load in the same word");

endmodule

// ----- test/tb_spi_register_burst_master_core.sv -----
// ----------------------------------------------------------------------------
// tb_spi_register_burst_master_core
// Self-checking bench for the SPI mode 3 register burst master.
// A short table of directed words (idle ticks, field extremes, a zero-count
// write, a start while busy, a read start) is followed by random bursts of
// random direction, address, length and pin data. One burst is 32 bytes
// long. Each result word is checked field by field against a table result
// or an in-bench sequencer model. Both channels idle at random, the receiver
// holds off once for a long stretch, and the sender once drains the block.
// ----------------------------------------------------------------------------
module tb_spi_register_burst_master_core;
	timeunit 1ns;
	timeprecision 1ps;

	import srbm_pkg::*;

	localparam int RANDOM_WORDS = 850;
	localparam int LONG_HOLD    = 150;
	localparam int HOLD_AT      = 300;
	localparam int DRAIN_CYCLES = 20;

	localparam result_t RES_IDLE  = '{ncs: 1'b1, sck: 1'b1, default: '0};
	localparam result_t RES_START = '{ncs: 1'b0, sck: 1'b1, busy_res: 1'b1, default: '0};

	typedef struct {
		item_t   w;
		bit      typed;
		result_t res;
	} dir_row_t;

	// zero-count write to 63 (command byte 0x7F), a start while busy, then a read start
	dir_row_t dir_tab [21] = '{
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h00, 1'b0}, 1'b1, RES_IDLE},
		'{'{CMD_TICK,  6'd63, 1'b1, 8'd255, 8'hFF, 1'b1}, 1'b1, RES_IDLE},
		'{'{CMD_START, 6'd63, 1'b0, 8'd0,   8'h3C, 1'b0}, 1'b1, RES_START},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h11, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h22, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h33, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h44, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h55, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h66, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h77, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_START, 6'd0,  1'b1, 8'd255, 8'h00, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h88, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h99, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'hAA, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'hBB, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'hCC, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'hDD, 1'b0}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'hEE, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd0,  1'b0, 8'd0,   8'h0F, 1'b1}, 1'b0, RES_IDLE},
		'{'{CMD_TICK,  6'd21, 1'b1, 8'd7,   8'h55, 1'b1}, 1'b1, RES_IDLE},
		'{'{CMD_START, 6'd0,  1'b1, 8'd1,   8'hC3, 1'b0}, 1'b1, RES_START}
	};

	logic clk = 1'b0;
	logic arst_n;

	srbm_item_if   item_ch ();
	srbm_result_if result_ch ();

	spi_register_burst_master_core #(
		.COUNT_WIDTH(COUNT_WIDTH_DEF)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #5ns clk = ~clk;

	// sequencer model state
	seq_state_t sq_state;
	logic [7:0] sq_shift;
	logic [2:0] sq_bit;
	logic       sq_phase;
	logic [7:0] sq_left;
	logic       sq_read;

	result_t pending_q [$];
	int      fails;
	int      words_out;

	function automatic result_t spi_half_bit(item_t w);
		result_t    r;
		logic [2:0] b;
		r = RES_IDLE;
		b = sq_bit;
		if (!(sq_state == ST_CMD || sq_state == ST_DATA)) begin
			sq_state = ST_IDLE;
			if (w.cmd == CMD_START) begin
				sq_state = ST_CMD;
				sq_shift = {2'b00, w.reg_addr} | CMD_AINC_FLAG
					| (w.is_read ? CMD_READ_FLAG : 8'h00);
				sq_bit   = 3'd7;
				sq_phase = 1'b1;
				sq_left  = w.byte_count;
				sq_read  = w.is_read;
				r.ncs      = 1'b0;
				r.busy_res = 1'b1;
			end
		end else begin
			r.ncs      = 1'b0;
			r.busy_res = 1'b1;
			r.mosi     = sq_shift[b];
			if (sq_phase) begin
				sq_phase = 1'b0;
				r.sck    = 1'b0;
			end else begin
				sq_phase    = 1'b1;
				r.sck       = 1'b1;
				sq_shift[b] = w.miso;
				if (b != 3'd0) begin
					sq_bit = b - 3'd1;
				end else begin
					if (sq_state == ST_DATA && sq_read) begin
						r.rdata       = sq_shift;
						r.rdata_valid = 1'b1;
					end
					sq_bit = 3'd7;
					if (sq_left == 8'd0) begin
						r.last   = 1'b1;
						sq_state = ST_IDLE;
					end else begin
						sq_left  = sq_left - 8'd1;
						sq_state = ST_DATA;
						if (sq_read) begin
							sq_shift = READ_FILL;
						end else begin
							sq_shift      = w.wdata;
							r.wdata_taken = 1'b1;
						end
					end
				end
			end
		end
		return r;
	endfunction

	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// offer one word, hold it until accepted, then record its expected result
	task automatic send_word(item_t w, bit typed, result_t typed_res, int gap);
		result_t p;
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		do
			@(posedge clk);
		while (!item_ch.ready);
		p = spi_half_bit(w);
		pending_q.push_back(typed ? typed_res : p);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		item_t w;
		int    n_rand;
		bit    big_done;
		bit    in_big;
		bit    paused;
		bit    calm_tx;
		bit    idle;
		int    r;
		arst_n        <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data  <= '0;
		sq_state = ST_IDLE;
		sq_shift = 8'h00;
		sq_bit   = 3'd7;
		sq_phase = 1'b1;
		sq_left  = 8'd0;
		sq_read  = 1'b0;
		n_rand   = 0;
		big_done = 1'b0;
		in_big   = 1'b0;
		paused   = 1'b0;
		calm_tx  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].res, pick_gap(1'b0));

		while (n_rand < RANDOM_WORDS || in_big) begin
			if (n_rand % 64 == 0)
				calm_tx = ($urandom_range(0, 3) == 0);
			w.cmd        = CMD_TICK;
			w.reg_addr   = 6'($urandom);
			w.is_read    = 1'($urandom);
			w.byte_count = 8'($urandom);
			w.wdata      = 8'($urandom);
			w.miso       = 1'($urandom);
			idle = !(sq_state == ST_CMD || sq_state == ST_DATA);
			if (idle) begin
				in_big = 1'b0;
				// mostly start a new burst, sometimes an idle tick of noise
				if ($urandom_range(0, 7) != 0) begin
					w.cmd = CMD_START;
					if (!big_done && n_rand >= RANDOM_WORDS / 4) begin
						w.byte_count = 8'd32;
						big_done     = 1'b1;
						in_big       = 1'b1;
					end else begin
						r = $urandom_range(0, 99);
						if (r < 60)
							w.byte_count = 8'($urandom_range(0, 2));
						else if (r < 90)
							w.byte_count = 8'($urandom_range(3, 8));
						else
							w.byte_count = 8'($urandom_range(9, 24));
					end
				end
			end else if ($urandom_range(0, 19) == 0) begin
				w.cmd = CMD_START;
			end
			if (!idle || w.cmd == CMD_START)
				n_rand++;
			// drain the block once before going on
			if (!paused && n_rand >= RANDOM_WORDS * 2 / 3) begin
				paused = 1'b1;
				item_ch.valid <= 1'b0;
				while (pending_q.size() != 0)
					@(posedge clk);
			end
			send_word(w, 1'b0, RES_IDLE, pick_gap(calm_tx));
		end

		item_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// receiver: random stalls, calm stretches, and one long hold-off
	initial begin
		int stall;
		int cyc;
		bit held;
		bit calm_rx;
		stall   = 0;
		cyc     = 0;
		held    = 1'b0;
		calm_rx = 1'b0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 128 == 0)
				calm_rx = ($urandom_range(0, 3) == 0);
			if (!held && words_out >= HOLD_AT) begin
				held  = 1'b1;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
				if (!calm_rx && $urandom_range(0, 3) == 0)
					stall = pick_gap(1'b0);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			words_out++;
			got = result_ch.data;
			if (pending_q.size() == 0) begin
				$error("result word with no expected word pending");
				fails++;
			end else begin
				want = pending_q.pop_front();
				check_field("ncs",         8'(want.ncs),         8'(got.ncs));
				check_field("sck",         8'(want.sck),         8'(got.sck));
				check_field("mosi",        8'(want.mosi),        8'(got.mosi));
				check_field("rdata",       want.rdata,           got.rdata);
				check_field("rdata_valid", 8'(want.rdata_valid), 8'(got.rdata_valid));
				check_field("last",        8'(want.last),        8'(got.last));
				check_field("wdata_taken", 8'(want.wdata_taken), 8'(got.wdata_taken));
				check_field("busy_res",    8'(want.busy_res),    8'(got.busy_res));
			end
		end
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

endmodule
